/* sv/lend_pkg.sv */
// ----------------------------------------------------------------------------
// lend_pkg: shared types and constants of the lane-edge narrowing detector
// Image geometry, register map, per-row descriptor, result record.
// ----------------------------------------------------------------------------
package lend_pkg;

  localparam int IMAGE_WIDTH  = 128;
  localparam int IMAGE_HEIGHT = 64;

  // rows that may count as clean
  localparam int CLEAN_ROW_FIRST  = 10;
  localparam int CLEAN_ROW_MARGIN = 5;

  localparam logic [8:0] EDGE_MAX      = 9'(IMAGE_WIDTH - 1);
  localparam logic [8:0] CLEAN_ROW_LO  = 9'(CLEAN_ROW_FIRST);
  localparam logic [8:0] CLEAN_ROW_END = 9'(IMAGE_HEIGHT - CLEAN_ROW_MARGIN);

  // average reported when no row gave a width
  localparam logic [12:0] AVG_EMPTY = 13'(IMAGE_WIDTH * 16);
  localparam logic [8:0]  WIDTH_EMPTY = 9'(IMAGE_WIDTH);

  localparam logic [12:0] AVG_POS_MAX = 13'h0FFF;
  localparam logic [12:0] AVG_NEG_MIN = 13'h1000;

  // quotient bits of (|total| * 16) / rows
  localparam int DIV_STEPS = 19;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // register map (word index)
  localparam int CFG_ADDR_W = 5;
  localparam logic [2:0] REG_WIN_FIRST   = 3'd0;
  localparam logic [2:0] REG_WIN_LAST    = 3'd1;
  localparam logic [2:0] REG_BORDER_TOL  = 3'd2;
  localparam logic [2:0] REG_ROW_QUOTA   = 3'd3;
  localparam logic [2:0] REG_ENTER_WMAX  = 3'd4;
  localparam logic [2:0] REG_EXIT_WMIN   = 3'd5;
  localparam logic [2:0] REG_ENTER_FRMS  = 3'd6;
  localparam logic [2:0] REG_EXIT_FRMS   = 3'd7;

  localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
  localparam logic [1:0] SIDE_LEFT    = 2'd1;
  localparam logic [1:0] SIDE_RIGHT   = 2'd2;

  typedef struct packed {
    logic [5:0] win_first;
    logic [5:0] win_last;
    logic [6:0] border_tol;
    logic [6:0] row_quota;
    logic [7:0] enter_wmax;
    logic [7:0] exit_wmin;
    logic [7:0] enter_frames;
    logic [7:0] exit_frames;
  } lend_cfg_t;

  // classified row; pin, width and clean flags already gated by the window
  typedef struct packed {
    logic              pin_l;
    logic              pin_r;
    logic              has_w;
    logic signed [8:0] w;
    logic              clean;
    logic              frame_end;
    logic              narrow_zone;
  } lend_row_t;

  typedef struct packed {
    logic signed [12:0] width_avg_q4;
    logic               left_pinned;
    logic               right_pinned;
    logic [1:0]         side;
    logic               entry_armed;
    logic               leave_armed;
    logic               entry_hit;
    logic               leave_hit;
    logic [7:0]         entry_tally;
    logic [7:0]         leave_tally;
  } lend_result_t;

endpackage

/* sv/lend_front.sv */
// ----------------------------------------------------------------------------
// lend_front: row classifier
// Window test, border pinning, usable width and clean-row test of one row.
// ----------------------------------------------------------------------------
module lend_front import lend_pkg::*; (
  input  lend_cfg_t  cfg_i,
  input  logic [5:0] row_index_i,
  input  logic [6:0] left_edge_i,
  input  logic [6:0] right_edge_i,
  input  logic       frame_end_i,
  input  logic       narrow_zone_i,
  output lend_row_t  row_o
);

  logic signed [8:0] left_s, right_s, tol_s, hi_s;
  logic [8:0]        row_u;
  logic              in_win, pin_l, pin_r, ok_l, ok_r, edges_inner, rows_inner;

  always_comb begin
    left_s  = signed'({2'b00, left_edge_i});
    right_s = signed'({2'b00, right_edge_i});
    tol_s   = signed'({2'b00, cfg_i.border_tol});
    hi_s    = signed'(EDGE_MAX) - tol_s;
    row_u   = {3'b000, row_index_i};

    in_win = (row_index_i >= cfg_i.win_first) && (row_index_i <= cfg_i.win_last);
    pin_l  = left_s <= tol_s;
    pin_r  = right_s >= hi_s;
    ok_l   = (left_s > tol_s) && (left_s < hi_s);
    ok_r   = (right_s > tol_s) && (right_s < hi_s);

    edges_inner = (left_edge_i != 7'd0) && ({2'b00, left_edge_i} < EDGE_MAX) &&
                  (right_edge_i != 7'd0) && ({2'b00, right_edge_i} < EDGE_MAX);
    rows_inner  = (row_u >= CLEAN_ROW_LO) && (row_u < CLEAN_ROW_END);

    row_o.has_w = 1'b0;
    row_o.w     = '0;
    if (ok_l && ok_r) begin
      row_o.has_w = in_win;
      row_o.w     = right_s - left_s;
    end else if (ok_l && pin_r) begin
      row_o.has_w = in_win;
      row_o.w     = signed'(EDGE_MAX) - left_s;
    end else if (ok_r && pin_l) begin
      row_o.has_w = in_win;
      row_o.w     = right_s;
    end

    row_o.pin_l       = in_win && pin_l;
    row_o.pin_r       = in_win && pin_r;
    row_o.clean       = in_win && edges_inner && rows_inner && !pin_l && !pin_r;
    row_o.frame_end   = frame_end_i;
    row_o.narrow_zone = narrow_zone_i;
  end

endmodule

/* sv/lend_queue.sv */
// ----------------------------------------------------------------------------
// lend_queue: short row queue
// Small flop FIFO between the classifier and the frame accumulator.
// ----------------------------------------------------------------------------
module lend_queue import lend_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lend_row_t push_data_i,
  input  logic      pop_i,
  output lend_row_t pop_data_o,
  output logic      full_o,
  output logic      empty_o
);

  lend_row_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]     count_q, count_d;
  logic                     do_push, do_pop;

  assign full_o     = count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* sv/lend_back.sv */
// ----------------------------------------------------------------------------
// lend_back: frame accumulator and frame-end evaluator
// Sums queued rows; on the frame-end row divides, tests and debounces.
// ----------------------------------------------------------------------------
module lend_back import lend_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lend_cfg_t    cfg_i,
  input  logic         q_empty_i,
  input  lend_row_t    q_data_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lend_result_t out_o
);

  localparam logic [1:0] ST_ACC   = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [6:0]            lp_q, lp_d, rp_q, rp_d, wr_q, wr_d, cl_q, cl_d;
  logic signed [14:0]    tot_q, tot_d;
  logic [7:0]            enc_q, enc_d, exc_q, exc_d;
  logic                  bridge_q, bridge_d;
  logic                  neg_q, neg_d;
  logic [14:0]           prod_en_q, prod_en_d, prod_ex_q, prod_ex_d;
  logic [DIV_STEPS-1:0]  div_q, div_d;
  logic [6:0]            rem_q, rem_d;
  logic [DIV_CNT_W-1:0]  step_q, step_d;
  logic                  out_valid_q, out_valid_d;
  lend_result_t          out_q, out_d;

  logic signed [15:0]    sum;
  logic [15:0]           neg_tot;
  logic [14:0]           mag;
  logic [7:0]            trial;
  logic                  ge, out_free, below, above, pl, pr, en_rdy, ex_rdy;
  logic [12:0]           avg;
  logic [7:0]            cnt_next;

  function automatic logic [6:0] sat7(input logic [6:0] v);
    sat7 = (v == 7'h7F) ? v : v + 7'd1;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign q_pop_o  = (state_q == ST_ACC) && !q_empty_i;

  always_comb begin
    state_d     = state_q;
    lp_d        = lp_q;
    rp_d        = rp_q;
    wr_d        = wr_q;
    cl_d        = cl_q;
    tot_d       = tot_q;
    enc_d       = enc_q;
    exc_d       = exc_q;
    bridge_d    = bridge_q;
    neg_d       = neg_q;
    prod_en_d   = prod_en_q;
    prod_ex_d   = prod_ex_q;
    div_d       = div_q;
    rem_d       = rem_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    sum     = 16'(tot_q) + 16'(q_data_i.w);
    neg_tot = -{tot_q[14], tot_q};
    mag     = tot_q[14] ? neg_tot[14:0] : tot_q;
    trial   = {rem_q, div_q[DIV_STEPS-1]};
    ge      = trial >= {1'b0, wr_q};

    avg = AVG_EMPTY;
    if (wr_q != '0) begin
      if (!neg_q) begin
        avg = (div_q > DIV_STEPS'(AVG_POS_MAX)) ? AVG_POS_MAX : div_q[12:0];
      end else begin
        avg = (div_q > DIV_STEPS'(AVG_NEG_MIN)) ? AVG_NEG_MIN : ~div_q[12:0] + 13'd1;
      end
    end
    if (wr_q == '0) begin
      below = WIDTH_EMPTY < {1'b0, cfg_i.enter_wmax};
      above = WIDTH_EMPTY > {1'b0, cfg_i.exit_wmin};
    end else begin
      below = signed'({{2{tot_q[14]}}, tot_q}) < signed'({2'b00, prod_en_q});
      above = signed'({{2{tot_q[14]}}, tot_q}) > signed'({2'b00, prod_ex_q});
    end
    pl       = lp_q >= cfg_i.row_quota;
    pr       = rp_q >= cfg_i.row_quota;
    en_rdy   = !bridge_q && below && (pl || pr);
    ex_rdy   = bridge_q && above && (cl_q >= cfg_i.row_quota);
    cnt_next = '0;

    case (state_q)
      ST_ACC: begin
        if (!q_empty_i) begin
          if (q_data_i.pin_l) lp_d = sat7(lp_q);
          if (q_data_i.pin_r) rp_d = sat7(rp_q);
          if (q_data_i.clean) cl_d = sat7(cl_q);
          if (q_data_i.has_w) begin
            wr_d = sat7(wr_q);
            if (sum > 16'sd16383) begin
              tot_d = 15'sh3FFF;
            end else if (sum < -16'sd16384) begin
              tot_d = 15'sh4000;
            end else begin
              tot_d = sum[14:0];
            end
          end
          if (q_data_i.frame_end) begin
            bridge_d = q_data_i.narrow_zone;
            state_d  = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        neg_d     = tot_q[14];
        div_d     = {mag, 4'b0000};
        rem_d     = '0;
        step_d    = DIV_CNT_W'(DIV_STEPS);
        prod_en_d = 15'(cfg_i.enter_wmax * wr_q);
        prod_ex_d = 15'(cfg_i.exit_wmin * wr_q);
        state_d   = (wr_q == '0) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        // one quotient bit per cycle
        rem_d  = ge ? 7'(trial - {1'b0, wr_q}) : trial[6:0];
        div_d  = {div_q[DIV_STEPS-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == DIV_CNT_W'(1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_d.width_avg_q4 = signed'(avg);
          out_d.left_pinned  = pl;
          out_d.right_pinned = pr;
          out_d.side         = (pr && !pl) ? SIDE_LEFT :
                               (pl && !pr) ? SIDE_RIGHT : SIDE_UNKNOWN;
          out_d.entry_armed  = en_rdy;
          out_d.leave_armed  = ex_rdy;
          out_d.entry_hit    = 1'b0;
          out_d.leave_hit    = 1'b0;
          if (!bridge_q) begin
            cnt_next = en_rdy ? ((enc_q == 8'hFF) ? enc_q : enc_q + 8'd1) : 8'd0;
            exc_d    = '0;
            if (cnt_next >= cfg_i.enter_frames) begin
              out_d.entry_hit = 1'b1;
              cnt_next        = '0;
            end
            enc_d = cnt_next;
          end else begin
            cnt_next = ex_rdy ? ((exc_q == 8'hFF) ? exc_q : exc_q + 8'd1) : 8'd0;
            enc_d    = '0;
            if (cnt_next >= cfg_i.exit_frames) begin
              out_d.leave_hit = 1'b1;
              cnt_next        = '0;
            end
            exc_d = cnt_next;
          end
          out_d.entry_tally = enc_d;
          out_d.leave_tally = exc_d;
          out_valid_d       = 1'b1;
          // start the next frame empty
          lp_d    = '0;
          rp_d    = '0;
          wr_d    = '0;
          cl_d    = '0;
          tot_d   = '0;
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      lp_q        <= '0;
      rp_q        <= '0;
      wr_q        <= '0;
      cl_q        <= '0;
      tot_q       <= '0;
      enc_q       <= '0;
      exc_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lp_q        <= lp_d;
      rp_q        <= rp_d;
      wr_q        <= wr_d;
      cl_q        <= cl_d;
      tot_q       <= tot_d;
      enc_q       <= enc_d;
      exc_q       <= exc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bridge_q  <= bridge_d;
    neg_q     <= neg_d;
    prod_en_q <= prod_en_d;
    prod_ex_q <= prod_ex_d;
    div_q     <= div_d;
    rem_q     <= rem_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_pop_only_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_ACC)
    else $error("row taken from queue outside accumulation");

  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> step_q != '0)
    else $error("divider ran past its last step");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result appeared without frame evaluation");

  a_one_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(enc_q != '0 && exc_q != '0))
    else $error("both debounce counters running");

  a_clear_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> wr_q == '0 && tot_q == '0)
    else $error("frame counts not cleared at frame end");

endmodule

/* sv/lane_edge_narrowing_detector_top.sv */
// ----------------------------------------------------------------------------
// lane_edge_narrowing_detector_top: lane-edge narrowing detector
// Per-frame road width, border pinning and narrow-section debounce.
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// rows    | in        | in_valid_i/in_stall_o   | row_index, left/right_edge, frame_end, narrow_zone
// result  | out       | out_valid_o/out_stall_i | width_avg_q4, pinned, side, armed/hit, tallies
// config  | in        | APB psel/penable/pready | eight registers at 4*i
//
// Ordinary rows are classified combinationally into a 4-entry queue. A frame-end
// row passes through setup, the bit-serial divider when the frame had width rows,
// and the final evaluation, while the queue keeps taking rows until full.
// Reset restores register defaults and zeroes frame counts and debounce.
// A held result stalls only the evaluator; the queue still fills.
// ----------------------------------------------------------------------------
module lane_edge_narrowing_detector_top import lend_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [5:0]            row_index_i,
  input  logic [6:0]            left_edge_i,
  input  logic [6:0]            right_edge_i,
  input  logic                  frame_end_i,
  input  logic                  narrow_zone_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [12:0]    width_avg_q4_o,
  output logic                  left_pinned_o,
  output logic                  right_pinned_o,
  output logic [1:0]            side_o,
  output logic                  entry_armed_o,
  output logic                  leave_armed_o,
  output logic                  entry_hit_o,
  output logic                  leave_hit_o,
  output logic [7:0]            entry_tally_o,
  output logic [7:0]            leave_tally_o
);

  lend_cfg_t    cfg_q, cfg_d;
  lend_row_t    row_cls, row_head;
  lend_result_t res;
  logic         q_full, q_empty, q_pop, cfg_wr;
  logic [2:0]   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_WIN_FIRST:  cfg_d.win_first    = pwdata[5:0];
        REG_WIN_LAST:   cfg_d.win_last     = pwdata[5:0];
        REG_BORDER_TOL: cfg_d.border_tol   = pwdata[6:0];
        REG_ROW_QUOTA:  cfg_d.row_quota    = pwdata[6:0];
        REG_ENTER_WMAX: cfg_d.enter_wmax   = pwdata[7:0];
        REG_EXIT_WMIN:  cfg_d.exit_wmin    = pwdata[7:0];
        REG_ENTER_FRMS: cfg_d.enter_frames = pwdata[7:0];
        REG_EXIT_FRMS:  cfg_d.exit_frames  = pwdata[7:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIN_FIRST:  prdata = {26'd0, cfg_q.win_first};
      REG_WIN_LAST:   prdata = {26'd0, cfg_q.win_last};
      REG_BORDER_TOL: prdata = {25'd0, cfg_q.border_tol};
      REG_ROW_QUOTA:  prdata = {25'd0, cfg_q.row_quota};
      REG_ENTER_WMAX: prdata = {24'd0, cfg_q.enter_wmax};
      REG_EXIT_WMIN:  prdata = {24'd0, cfg_q.exit_wmin};
      REG_ENTER_FRMS: prdata = {24'd0, cfg_q.enter_frames};
      REG_EXIT_FRMS:  prdata = {24'd0, cfg_q.exit_frames};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_first    <= 6'd20;
      cfg_q.win_last     <= 6'd50;
      cfg_q.border_tol   <= 7'd3;
      cfg_q.row_quota    <= 7'd5;
      cfg_q.enter_wmax   <= 8'd60;
      cfg_q.exit_wmin    <= 8'd70;
      cfg_q.enter_frames <= 8'd3;
      cfg_q.exit_frames  <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign in_stall_o = q_full;

  lend_front u_front (
    .cfg_i         (cfg_q),
    .row_index_i   (row_index_i),
    .left_edge_i   (left_edge_i),
    .right_edge_i  (right_edge_i),
    .frame_end_i   (frame_end_i),
    .narrow_zone_i (narrow_zone_i),
    .row_o         (row_cls)
  );

  lend_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (row_cls),
    .pop_i       (q_pop),
    .pop_data_o  (row_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  lend_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (row_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign width_avg_q4_o = res.width_avg_q4;
  assign left_pinned_o  = res.left_pinned;
  assign right_pinned_o = res.right_pinned;
  assign side_o         = res.side;
  assign entry_armed_o  = res.entry_armed;
  assign leave_armed_o  = res.leave_armed;
  assign entry_hit_o    = res.entry_hit;
  assign leave_hit_o    = res.leave_hit;
  assign entry_tally_o  = res.entry_tally;
  assign leave_tally_o  = res.leave_tally;

endmodule
